[rtl/kic_pkg.sv]
`timescale 1ns / 1ps
// Package for the keypad integer calculator: shared types, codes and the key decode table.
// Depends on nothing; used by every module in this folder.
package kic_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OUT_WIDTH      = 32;
    localparam int DIGIT_BASE     = 10;

    // Event codes on the request channel
    typedef enum logic [1:0] {
        OP_KEY = 2'd0,
        OP_INC = 2'd1,
        OP_DEC = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_OPER   = 2'd2,
        PH_RESULT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OPR_ADD = 2'd0,
        OPR_SUB = 2'd1,
        OPR_MUL = 2'd2,
        OPR_DIV = 2'd3
    } t_oper;

    typedef enum logic [1:0] {
        KIND_DIGIT  = 2'd0,
        KIND_OPER   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_EQUALS = 2'd3
    } t_key_kind;

    typedef struct packed {
        t_key_kind  kind;
        logic [3:0] val;
    } t_key;

    // Serial unit commands
    typedef enum logic [1:0] {
        UOP_ADD = 2'd0,
        UOP_SUB = 2'd1,
        UOP_MUL = 2'd2,
        UOP_DIV = 2'd3
    } t_uop;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_FIX,
        U_DONE
    } t_ustate;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DST_FIRST,
        DST_SECOND,
        DST_RESULT
    } t_dest;

    // 4x4 matrix: 7 8 9 / | 4 5 6 * | 1 2 3 - | C 0 = +
    function automatic t_key key_decode(input logic [1:0] row, input logic [1:0] col);
        t_key k;
        unique case ({row, col})
            4'h0: k = '{KIND_DIGIT, 4'd7};
            4'h1: k = '{KIND_DIGIT, 4'd8};
            4'h2: k = '{KIND_DIGIT, 4'd9};
            4'h3: k = '{KIND_OPER, {2'b00, OPR_DIV}};
            4'h4: k = '{KIND_DIGIT, 4'd4};
            4'h5: k = '{KIND_DIGIT, 4'd5};
            4'h6: k = '{KIND_DIGIT, 4'd6};
            4'h7: k = '{KIND_OPER, {2'b00, OPR_MUL}};
            4'h8: k = '{KIND_DIGIT, 4'd1};
            4'h9: k = '{KIND_DIGIT, 4'd2};
            4'hA: k = '{KIND_DIGIT, 4'd3};
            4'hB: k = '{KIND_OPER, {2'b00, OPR_SUB}};
            4'hC: k = '{KIND_CLEAR, 4'd0};
            4'hD: k = '{KIND_DIGIT, 4'd0};
            4'hE: k = '{KIND_EQUALS, 4'd0};
            4'hF: k = '{KIND_OPER, {2'b00, OPR_ADD}};
            default: k = '{KIND_CLEAR, 4'd0};
        endcase
        return k;
    endfunction

endpackage

[rtl/kic_serial_unit.sv]
`timescale 1ns / 1ps
// Shared radix-2 arithmetic unit: add/sub, shift-add multiply with addend,
// restoring signed divide producing one quotient bit per cycle. Depends on kic_pkg.
module kic_serial_unit import kic_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_uop         i_uop,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_c,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int CNT_W = $clog2(W);

    t_ustate          r_state, n_state;
    logic [W-1:0]     r_acc, n_acc;      // accumulator / partial remainder
    logic [W-1:0]     r_mcand, n_mcand;  // multiplicand / divisor magnitude
    logic [W-1:0]     r_mplier, n_mplier; // multiplier / dividend-quotient shifter
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [W-1:0] shifted;
    logic [W:0]   diff;

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    // Divide step: bring down next dividend bit, trial subtract
    assign shifted = {r_acc[W-2:0], r_mplier[W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, r_mcand};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        o_done   = 1'b0;
        unique case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_cnt = CNT_W'(W - 1);
                    unique case (i_uop)
                        UOP_ADD: begin
                            n_acc   = i_a + i_b;
                            n_state = U_DONE;
                        end
                        UOP_SUB: begin
                            n_acc   = i_a - i_b;
                            n_state = U_DONE;
                        end
                        UOP_MUL: begin
                            n_acc    = i_c;
                            n_mcand  = i_a;
                            n_mplier = i_b;
                            n_state  = U_MUL;
                        end
                        UOP_DIV: begin
                            n_acc    = '0;
                            n_mplier = i_a[W-1] ? ({W{1'b0}} - i_a) : i_a;
                            n_mcand  = i_b[W-1] ? ({W{1'b0}} - i_b) : i_b;
                            n_neg    = i_a[W-1] ^ i_b[W-1];
                            n_state  = U_DIV;
                        end
                        default: n_state = U_IDLE;
                    endcase
                end
            end
            U_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[W-1:1]};
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = U_DONE;
                end
            end
            U_DIV: begin
                if (!diff[W]) begin
                    n_acc    = diff[W-1:0];
                    n_mplier = {r_mplier[W-2:0], 1'b1};
                end else begin
                    n_acc    = shifted;
                    n_mplier = {r_mplier[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = U_FIX;
                end
            end
            U_FIX: begin
                // quotient sign; most negative over minus one wraps to itself
                n_acc   = r_neg ? ({W{1'b0}} - r_mplier) : r_mplier;
                n_state = U_DONE;
            end
            U_DONE: begin
                o_done  = 1'b1;
                n_state = U_IDLE;
            end
            default: n_state = U_IDLE;
        endcase
    end

    assign o_result = r_acc;

endmodule

[rtl/keypad_integer_calculator_core.sv]
`timescale 1ns / 1ps
// Keypad four-function calculator core: phase/operand control and output register.
// Depends on kic_pkg and kic_serial_unit.
//
// Usage:
//  Request channel: i_valid/o_stall with i_op (0 key, 1 increment, 2 decrement),
//  i_key_row and i_key_col of the 4x4 keypad. A request is taken when i_valid is
//  high and o_stall is low. o_stall is high while a request is being worked on.
//  Result channel: o_valid/i_stall. Exactly one result per request, carrying the
//  state after the event and o_accepted (0 when the event was ignored).
//  Events with no arithmetic skip the serial unit. Add/sub on equals
//  and increment/decrement pass through the shared serial unit. Digit entry into
//  an operand and multiply run a shift-add loop (one multiplier bit per cycle),
//  divide a restoring loop (one quotient bit per cycle plus sign fix-up).
//  Requests are handled one at a time; the next one is taken the cycle after
//  the previous result is loaded into the output register.
//  The output register holds the last result; the next request is taken while it
//  waits, and a finished result waits in the core until the output is taken.
//  Reset (synchronous, active low) clears phase, operator, operands, result and
//  the divide-by-zero flag, and empties the output register.
//  A stalled result stays on the outputs unchanged until taken.
module keypad_integer_calculator_core import kic_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [1:0]                  i_key_row,
    input  logic [1:0]                  i_key_col,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_phase,
    output logic [1:0]                  o_operator_code,
    output logic signed [OUT_WIDTH-1:0] o_first_operand,
    output logic signed [OUT_WIDTH-1:0] o_second_operand,
    output logic signed [OUT_WIDTH-1:0] o_result_value,
    output logic                        o_divide_by_zero,
    output logic                        o_accepted
);

    localparam int W = DATA_WIDTH;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    t_oper           r_oper, n_oper;
    logic [W-1:0]    r_first, n_first;
    logic [W-1:0]    r_second, n_second;
    logic [W-1:0]    r_result, n_result;
    logic            r_dz, n_dz;
    logic            r_acc, n_acc;
    t_dest           r_dest, n_dest;
    logic            r_o_valid, n_o_valid;

    logic [1:0]           r_o_phase, n_o_phase;
    logic [1:0]           r_o_oper, n_o_oper;
    logic [OUT_WIDTH-1:0] r_o_first, n_o_first;
    logic [OUT_WIDTH-1:0] r_o_second, n_o_second;
    logic [OUT_WIDTH-1:0] r_o_result, n_o_result;
    logic                 r_o_dz, n_o_dz;
    logic                 r_o_acc, n_o_acc;

    logic         in_take;
    t_key         key;
    logic         u_start;
    t_uop         u_op;
    logic [W-1:0] u_a, u_b, u_c;
    logic         u_done;
    logic [W-1:0] u_result;
    logic [W-1:0] digit;

    assign in_take = i_valid && (r_state == S_IDLE);
    assign key     = key_decode(i_key_row, i_key_col);
    assign digit   = W'(key.val);

    kic_serial_unit #(.W(W)) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (u_start),
        .i_uop    (u_op),
        .i_a      (u_a),
        .i_b      (u_b),
        .i_c      (u_c),
        .o_done   (u_done),
        .o_result (u_result)
    );

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_FIRST;
            r_oper    <= OPR_ADD;
            r_first   <= '0;
            r_second  <= '0;
            r_result  <= '0;
            r_dz      <= 1'b0;
            r_acc     <= 1'b0;
            r_dest    <= DST_FIRST;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_oper    <= n_oper;
            r_first   <= n_first;
            r_second  <= n_second;
            r_result  <= n_result;
            r_dz      <= n_dz;
            r_acc     <= n_acc;
            r_dest    <= n_dest;
            r_o_valid <= n_o_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_o_phase  <= n_o_phase;
        r_o_oper   <= n_o_oper;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_result <= n_o_result;
        r_o_dz     <= n_o_dz;
        r_o_acc    <= n_o_acc;
    end

    // Event decode, serial unit dispatch and write-back
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_oper     = r_oper;
        n_first    = r_first;
        n_second   = r_second;
        n_result   = r_result;
        n_dz       = r_dz;
        n_acc      = r_acc;
        n_dest     = r_dest;
        n_o_valid  = r_o_valid && i_stall;
        n_o_phase  = r_o_phase;
        n_o_oper   = r_o_oper;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_result = r_o_result;
        n_o_dz     = r_o_dz;
        n_o_acc    = r_o_acc;
        u_start    = 1'b0;
        u_op       = UOP_ADD;
        u_a        = r_first;
        u_b        = r_second;
        u_c        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_acc = 1'b0;
                    priority case (i_op)
                        OP_KEY: begin
                            unique case (key.kind)
                                KIND_CLEAR: begin
                                    n_acc    = 1'b1;
                                    n_phase  = PH_FIRST;
                                    n_first  = '0;
                                    n_second = '0;
                                end
                                KIND_OPER: begin
                                    if (r_phase == PH_FIRST || r_phase == PH_OPER) begin
                                        n_acc   = 1'b1;
                                        n_oper  = t_oper'(key.val[1:0]);
                                        n_phase = PH_OPER;
                                    end
                                end
                                KIND_EQUALS: begin
                                    if (r_phase == PH_SECOND) begin
                                        n_acc   = 1'b1;
                                        n_phase = PH_RESULT;
                                        n_dz    = 1'b0;
                                        n_dest  = DST_RESULT;
                                        unique case (r_oper)
                                            OPR_ADD: begin
                                                u_start = 1'b1;
                                                u_op    = UOP_ADD;
                                            end
                                            OPR_SUB: begin
                                                u_start = 1'b1;
                                                u_op    = UOP_SUB;
                                            end
                                            OPR_MUL: begin
                                                u_start = 1'b1;
                                                u_op    = UOP_MUL;
                                            end
                                            OPR_DIV: begin
                                                // divide by zero: result 0, flag set
                                                if (r_second == '0) begin
                                                    n_result = '0;
                                                    n_dz     = 1'b1;
                                                end else begin
                                                    u_start = 1'b1;
                                                    u_op    = UOP_DIV;
                                                end
                                            end
                                            default: n_dz = 1'b0;
                                        endcase
                                    end
                                end
                                KIND_DIGIT: begin
                                    n_acc = 1'b1;
                                    u_b   = W'(DIGIT_BASE);
                                    u_c   = digit;
                                    unique case (r_phase)
                                        PH_FIRST: begin
                                            u_start = 1'b1;
                                            u_op    = UOP_MUL;
                                            u_a     = r_first;
                                            n_dest  = DST_FIRST;
                                        end
                                        PH_SECOND: begin
                                            u_start = 1'b1;
                                            u_op    = UOP_MUL;
                                            u_a     = r_second;
                                            n_dest  = DST_SECOND;
                                        end
                                        PH_OPER: begin
                                            n_second = digit;
                                            n_phase  = PH_SECOND;
                                        end
                                        PH_RESULT: begin
                                            n_first = digit;
                                            n_phase = PH_FIRST;
                                        end
                                        default: n_phase = r_phase;
                                    endcase
                                end
                                default: n_acc = 1'b0;
                            endcase
                        end
                        OP_INC, OP_DEC: begin
                            if (r_phase == PH_RESULT) begin
                                n_acc   = 1'b1;
                                u_start = 1'b1;
                                u_op    = (i_op == OP_INC) ? UOP_ADD : UOP_SUB;
                                u_a     = r_result;
                                u_b     = W'(1);
                                n_dest  = DST_RESULT;
                            end
                        end
                        default: n_acc = 1'b0;
                    endcase
                    n_state = u_start ? S_BUSY : S_EMIT;
                end
            end
            S_BUSY: begin
                if (u_done) begin
                    unique case (r_dest)
                        DST_FIRST:  n_first  = u_result;
                        DST_SECOND: n_second = u_result;
                        DST_RESULT: n_result = u_result;
                        default:    n_result = r_result;
                    endcase
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_phase  = r_phase;
                    n_o_oper   = r_oper;
                    n_o_first  = OUT_WIDTH'(r_first);
                    n_o_second = OUT_WIDTH'(r_second);
                    n_o_result = OUT_WIDTH'(r_result);
                    n_o_dz     = r_dz;
                    n_o_acc    = r_acc;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_phase          = r_o_phase;
    assign o_operator_code  = r_o_oper;
    assign o_first_operand  = r_o_first;
    assign o_second_operand = r_o_second;
    assign o_result_value   = r_o_result;
    assign o_divide_by_zero = r_o_dz;
    assign o_accepted       = r_o_acc;

endmodule

[rtl/kic_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the keypad calculator core, attached by bind.
// Depends on kic_pkg and keypad_integer_calculator_core.
module kic_checker import kic_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [1:0]                  o_phase,
    input logic [1:0]                  o_operator_code,
    input logic signed [OUT_WIDTH-1:0] o_first_operand,
    input logic signed [OUT_WIDTH-1:0] o_second_operand,
    input logic signed [OUT_WIDTH-1:0] o_result_value,
    input logic                        o_divide_by_zero,
    input logic                        o_accepted
);

    // Reset leaves the core idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("core not idle after reset");

    // A taken request occupies the core in the next cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("core took a request but did not go busy");

    // A stalled result stays presented
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_phase) && $stable(o_operator_code)
            && $stable(o_first_operand) && $stable(o_second_operand)
            && $stable(o_result_value) && $stable(o_divide_by_zero)
            && $stable(o_accepted)))
        else $error("result payload changed while stalled");

endmodule

bind keypad_integer_calculator_core kic_checker u_kic_checker (.*);
